>>> src/lzd_pkg.sv
// Shared types, constants and the CRC-32 byte update for the LZSS/store decoder.
package lzd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int DIST_W          = 13;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int TDATA_OUT_W     = 48;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [3:0]  LEN_MASK = 4'hF;
    localparam logic [4:0]  LEN_BIAS = 5'd3;

    localparam logic [7:0] METHOD_STORE = 8'd0;
    localparam logic [7:0] METHOD_LZSS  = 8'd1;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENC      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_CRC  = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_METH  = 3'd1,
        ST_STORE_SZ  = 3'd2,
        ST_BAD_MATCH = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_SIZE      = 3'd5,
        ST_CRC       = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        P_FLAG = 2'd0,
        P_DATA = 2'd1,
        P_HIGH = 2'd2,
        P_END  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LIT   = 2'd1,
        CMD_COPY  = 2'd2,
        CMD_FIN   = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_EXEC = 2'd1,
        B_WAIT = 2'd2
    } bstate_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] offset;
        status_t           status;
        logic              check;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic       [7:0]  out_byte;
        logic              byte_valid;
        logic              done_res;
        status_t           status;
        logic       [31:0] final_crc;
        logic              last;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> src/lzss_store_decoder_crc32.sv
// Top level of the LZSS/store decoder with CRC-32 check.
// Decodes one file per start word (tuser 0) from encoded words (tuser 1). The
// front end classifies each accepted word and queues at most two commands;
// it stalls only when the four-entry queue lacks room for two commands. The
// back end fetches each command in B_IDLE and carries it out in B_EXEC; a
// match copy alternates B_EXEC, which issues the registered read of the
// window RAM, with B_WAIT, which writes and emits the byte. Literals, copies
// and end statuses wait while the output is stalled. Write the registers
// only while the decoder is idle.
module lzss_store_decoder_crc32 #(
    parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // in_byte[7:0]
    input  logic                              s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lzd_pkg::TDATA_OUT_W-1:0]   m_tdata,   // out_byte, status, final_crc, pad
    output logic [1:0]                        m_tuser,   // byte_valid, done_res
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic [7:0]       method_reg;
    logic [31:0]      orig_reg, enc_reg, exp_crc_reg;
    logic             take, room2, empty, pop;
    logic [1:0]       n_cmd;
    lzd_pkg::cmd_t    cmd0, cmd1, head;
    lzd_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = room2;
    assign take      = s_tvalid && room2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg  <= '0;
            orig_reg    <= '0;
            enc_reg     <= '0;
            exp_crc_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lzd_pkg::REG_METHOD:  method_reg  <= cfg_data[7:0];
                lzd_pkg::REG_ORIG:    orig_reg    <= cfg_data;
                lzd_pkg::REG_ENC:     enc_reg     <= cfg_data;
                lzd_pkg::REG_EXP_CRC: exp_crc_reg <= cfg_data;
                default:              method_reg  <= method_reg;
            endcase
        end
    end

    lzd_front #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .opcode    (s_tuser),
        .in_byte   (s_tdata),
        .method    (method_reg),
        .dec_total (orig_reg),
        .enc_total (enc_reg),
        .n_cmd     (n_cmd),
        .cmd0      (cmd0),
        .cmd1      (cmd1)
    );

    lzd_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .n_push (n_cmd),
        .push0  (cmd0),
        .push1  (cmd1),
        .pop    (pop),
        .head   (head),
        .empty  (empty),
        .room2  (room2)
    );

    lzd_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .crc_goal  (exp_crc_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'd0, res.final_crc, res.status, res.out_byte};
    assign m_tuser = {res.done_res, res.byte_valid};
    assign m_tlast = res.last;

endmodule

>>> src/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lzd_front.sv
// Front end: accepts encoded words, parses flags and tokens, issues commands.
module lzd_front #(
    parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                opcode,
    input  logic [7:0]          in_byte,
    input  logic [7:0]          method,
    input  logic [31:0]         dec_total,
    input  logic [31:0]         enc_total,
    output logic [1:0]          n_cmd,
    output lzd_pkg::cmd_t       cmd0,
    output lzd_pkg::cmd_t       cmd1
);

    localparam logic [lzd_pkg::DIST_W-1:0] WIN = lzd_pkg::DIST_W'(WINDOW_SIZE);

    logic [31:0]     prod_reg, prod_next;
    logic [31:0]     cons_reg, cons_next;
    logic [7:0]      flags_reg, flags_next;
    logic [3:0]      idx_reg, idx_next;
    logic [7:0]      low_reg, low_next;
    lzd_pkg::phase_t phase_reg, phase_next;

    logic                          main_v, fin_v, fin_check, adv, lz_fin;
    lzd_pkg::cmd_t                 main_cmd, fin_cmd;
    lzd_pkg::status_t              fin_st;
    logic [15:0]                   tok;
    logic [lzd_pkg::DIST_W-1:0]    tok_dist;
    logic [lzd_pkg::LEN_W-1:0]     len;
    logic [32:0]                   need;

    always_comb
    begin
        prod_next  = prod_reg;
        cons_next  = cons_reg;
        flags_next = flags_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        phase_next = phase_reg;
        main_v     = 1'b0;
        main_cmd   = '0;
        fin_v      = 1'b0;
        fin_check  = 1'b0;
        fin_st     = lzd_pkg::ST_OK;
        adv        = 1'b0;
        lz_fin     = 1'b0;
        need       = '0;
        tok        = {in_byte, low_reg};
        tok_dist   = lzd_pkg::DIST_W'(tok[15:4]) + lzd_pkg::DIST_W'(1);
        len        = lzd_pkg::LEN_W'(tok[3:0] & lzd_pkg::LEN_MASK) + lzd_pkg::LEN_BIAS;

        if (take)
        begin
            if (opcode == lzd_pkg::OP_START)
            begin
                prod_next     = '0;
                cons_next     = '0;
                flags_next    = '0;
                idx_next      = 4'd8;
                low_next      = '0;
                phase_next    = lzd_pkg::P_FLAG;
                main_v        = 1'b1;
                main_cmd.kind = lzd_pkg::CMD_CLEAR;
                if (method > lzd_pkg::METHOD_LZSS)
                begin
                    fin_v  = 1'b1;
                    fin_st = lzd_pkg::ST_BAD_METH;
                end
                else if (method == lzd_pkg::METHOD_STORE)
                begin
                    if (enc_total != dec_total)
                    begin
                        fin_v  = 1'b1;
                        fin_st = lzd_pkg::ST_STORE_SZ;
                    end
                    else if (enc_total == '0)
                    begin
                        fin_v     = 1'b1;
                        fin_check = 1'b1;
                    end
                end
                else if (enc_total == '0 || dec_total == '0)
                begin
                    lz_fin = 1'b1;
                end
            end
            else if (phase_reg == lzd_pkg::P_END)
            begin
                // file ended: drop the word
            end
            else if (method > lzd_pkg::METHOD_LZSS)
            begin
                fin_v  = 1'b1;
                fin_st = lzd_pkg::ST_BAD_METH;
            end
            else if (method == lzd_pkg::METHOD_STORE)
            begin
                if (enc_total != dec_total)
                begin
                    fin_v  = 1'b1;
                    fin_st = lzd_pkg::ST_STORE_SZ;
                end
                else if (cons_reg >= enc_total)
                begin
                    fin_v     = 1'b1;
                    fin_check = 1'b1;
                end
                else
                begin
                    cons_next     = cons_reg + 32'd1;
                    prod_next     = prod_reg + 32'd1;
                    main_v        = 1'b1;
                    main_cmd.kind = lzd_pkg::CMD_LIT;
                    main_cmd.data = in_byte;
                    if (cons_next >= enc_total)
                    begin
                        fin_v     = 1'b1;
                        fin_check = 1'b1;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    lzd_pkg::P_FLAG:
                    begin
                        if (cons_reg < enc_total && prod_reg < dec_total)
                        begin
                            cons_next  = cons_reg + 32'd1;
                            flags_next = in_byte;
                            idx_next   = 4'd0;
                            adv        = 1'b1;
                        end
                        else
                        begin
                            lz_fin = 1'b1;
                        end
                    end
                    lzd_pkg::P_DATA:
                    begin
                        cons_next = cons_reg + 32'd1;
                        if (flags_reg[idx_reg[2:0]])
                        begin
                            prod_next     = prod_reg + 32'd1;
                            main_v        = 1'b1;
                            main_cmd.kind = lzd_pkg::CMD_LIT;
                            main_cmd.data = in_byte;
                            idx_next      = idx_reg + 4'd1;
                            adv           = 1'b1;
                        end
                        else
                        begin
                            low_next   = in_byte;
                            phase_next = lzd_pkg::P_HIGH;
                        end
                    end
                    default:
                    begin
                        cons_next = cons_reg + 32'd1;
                        if (tok_dist > WIN || 32'(tok_dist) > prod_reg ||
                            ({1'b0, prod_reg} + 33'(len)) > {1'b0, dec_total})
                        begin
                            fin_v  = 1'b1;
                            fin_st = lzd_pkg::ST_BAD_MATCH;
                        end
                        else
                        begin
                            prod_next       = prod_reg + 32'(len);
                            main_v          = 1'b1;
                            main_cmd.kind   = lzd_pkg::CMD_COPY;
                            main_cmd.len    = len;
                            main_cmd.offset = tok_dist;
                            idx_next        = idx_reg + 4'd1;
                            adv             = 1'b1;
                        end
                    end
                endcase
            end
        end

        // decide what follows a completed flag byte or token
        if (adv)
        begin
            if (idx_next[3] || prod_next >= dec_total)
            begin
                if (cons_next < enc_total && prod_next < dec_total)
                begin
                    phase_next = lzd_pkg::P_FLAG;
                end
                else
                begin
                    lz_fin = 1'b1;
                end
            end
            else
            begin
                need = flags_next[idx_next[2:0]] ? 33'd1 : 33'd2;
                if ({1'b0, cons_next} + need > {1'b0, enc_total})
                begin
                    fin_v  = 1'b1;
                    fin_st = lzd_pkg::ST_TRUNC;
                end
                else
                begin
                    phase_next = lzd_pkg::P_DATA;
                end
            end
        end

        if (lz_fin)
        begin
            fin_v = 1'b1;
            if (cons_next == enc_total && prod_next == dec_total)
            begin
                fin_check = 1'b1;
            end
            else if (prod_next < dec_total)
            begin
                fin_st = lzd_pkg::ST_TRUNC;
            end
            else
            begin
                fin_st = lzd_pkg::ST_SIZE;
            end
        end

        if (fin_v)
        begin
            phase_next = lzd_pkg::P_END;
        end
    end

    always_comb
    begin
        fin_cmd        = '0;
        fin_cmd.kind   = lzd_pkg::CMD_FIN;
        fin_cmd.status = fin_st;
        fin_cmd.check  = fin_check;
        fin_cmd.last   = 1'b1;
        cmd0           = main_cmd;
        cmd1           = fin_cmd;
        cmd0.last      = !fin_v && main_cmd.kind != lzd_pkg::CMD_CLEAR;
        if (main_v && fin_v)
        begin
            n_cmd = 2'd2;
        end
        else if (main_v)
        begin
            n_cmd = 2'd1;
        end
        else if (fin_v)
        begin
            n_cmd = 2'd1;
            cmd0  = fin_cmd;
        end
        else
        begin
            n_cmd = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg  <= '0;
            cons_reg  <= '0;
            flags_reg <= '0;
            idx_reg   <= 4'd8;
            low_reg   <= '0;
            phase_reg <= lzd_pkg::P_FLAG;
        end
        else
        begin
            prod_reg  <= prod_next;
            cons_reg  <= cons_next;
            flags_reg <= flags_next;
            idx_reg   <= idx_next;
            low_reg   <= low_next;
            phase_reg <= phase_next;
        end
    end

endmodule

>>> src/lzd_cmd_fifo.sv
// Four-entry command queue between front and back, up to two pushes a cycle.
module lzd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    n_push,
    input  lzd_pkg::cmd_t push0,
    input  lzd_pkg::cmd_t push1,
    input  logic          pop,
    output lzd_pkg::cmd_t head,
    output logic          empty,
    output logic          room2
);

    lzd_pkg::cmd_t mem_reg [4];
    logic [1:0]    wptr_reg, rptr_reg;
    logic [2:0]    count_reg;

    assign head  = mem_reg[rptr_reg];
    assign empty = (count_reg == 3'd0);
    assign room2 = (count_reg <= 3'd2);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem_reg[wptr_reg] <= push0;
        end
        if (n_push == 2'd2)
        begin
            mem_reg[wptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + n_push;
            rptr_reg  <= rptr_reg + {1'b0, pop};
            count_reg <= count_reg + {1'b0, n_push} - {2'b0, pop};
        end
    end

endmodule

>>> src/lzd_back.sv
// Back end: carries out commands, keeps the history window and the CRC.
module lzd_back #(
    parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lzd_pkg::cmd_t   head,
    input  logic            empty,
    output logic            pop,
    input  logic [31:0]     crc_goal,
    output logic            res_valid,
    input  logic            res_ready,
    output lzd_pkg::result_t res
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam logic [lzd_pkg::DIST_W-1:0] WIN = lzd_pkg::DIST_W'(WINDOW_SIZE);

    lzd_pkg::bstate_t          state_reg, state_next;
    lzd_pkg::cmd_t             cmd_reg;
    logic [lzd_pkg::LEN_W-1:0] cnt_reg;
    logic [31:0]               crc_reg;
    logic [AW-1:0]             wp_reg;
    logic                      out_valid_reg;
    lzd_pkg::result_t          out_reg, out_next;

    logic                      out_ok, emit, wr_en, rd_en;
    logic [7:0]                rdata, emit_byte;
    logic [lzd_pkg::DIST_W-1:0] wp_ext, src;
    logic [AW-1:0]             wp_inc;

    assign out_ok = !out_valid_reg || res_ready;
    assign wp_ext = lzd_pkg::DIST_W'(wp_reg);
    assign src    = (wp_ext >= cmd_reg.offset) ? (wp_ext - cmd_reg.offset)
                                               : (wp_ext + WIN - cmd_reg.offset);
    assign wp_inc = (wp_ext == WIN - lzd_pkg::DIST_W'(1)) ? '0 : wp_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lzd_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = lzd_pkg::B_EXEC;
                end
            end
            lzd_pkg::B_EXEC:
            begin
                case (cmd_reg.kind)
                    lzd_pkg::CMD_CLEAR: state_next = lzd_pkg::B_IDLE;
                    lzd_pkg::CMD_COPY:  state_next = lzd_pkg::B_WAIT;
                    default:
                    begin
                        if (out_ok)
                        begin
                            state_next = lzd_pkg::B_IDLE;
                        end
                    end
                endcase
            end
            lzd_pkg::B_WAIT:
            begin
                if (out_ok)
                begin
                    state_next = (cnt_reg == lzd_pkg::LEN_W'(1)) ? lzd_pkg::B_IDLE
                                                                 : lzd_pkg::B_EXEC;
                end
            end
            default: state_next = lzd_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == lzd_pkg::B_IDLE) && !empty;
        rd_en     = (state_reg == lzd_pkg::B_EXEC) && (cmd_reg.kind == lzd_pkg::CMD_COPY);
        wr_en     = out_ok && (((state_reg == lzd_pkg::B_EXEC) &&
                                (cmd_reg.kind == lzd_pkg::CMD_LIT)) ||
                               (state_reg == lzd_pkg::B_WAIT));
        emit      = wr_en || (out_ok && (state_reg == lzd_pkg::B_EXEC) &&
                              (cmd_reg.kind == lzd_pkg::CMD_FIN));
        emit_byte = (state_reg == lzd_pkg::B_WAIT) ? rdata : cmd_reg.data;
    end

    always_comb
    begin
        out_next = '0;
        if (wr_en)
        begin
            out_next.out_byte   = emit_byte;
            out_next.byte_valid = 1'b1;
            out_next.last       = cmd_reg.last &&
                                  ((cmd_reg.kind == lzd_pkg::CMD_LIT) ||
                                   (cnt_reg == lzd_pkg::LEN_W'(1)));
        end
        else
        begin
            out_next.done_res  = 1'b1;
            out_next.final_crc = ~crc_reg;
            out_next.last      = cmd_reg.last;
            if (cmd_reg.check)
            begin
                out_next.status = (~crc_reg == crc_goal) ? lzd_pkg::ST_OK
                                                         : lzd_pkg::ST_CRC;
            end
            else
            begin
                out_next.status = cmd_reg.status;
            end
        end
    end

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (rd_en),
        .raddr (src[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzd_pkg::B_IDLE;
            cnt_reg       <= '0;
            crc_reg       <= lzd_pkg::CRC_INIT;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cnt_reg <= head.len;
            end
            else if (wr_en && state_reg == lzd_pkg::B_WAIT)
            begin
                cnt_reg <= cnt_reg - lzd_pkg::LEN_W'(1);
            end
            if (state_reg == lzd_pkg::B_EXEC && cmd_reg.kind == lzd_pkg::CMD_CLEAR)
            begin
                crc_reg <= lzd_pkg::CRC_INIT;
                wp_reg  <= '0;
            end
            else if (wr_en)
            begin
                crc_reg <= lzd_pkg::crc_byte(crc_reg, emit_byte);
                wp_reg  <= wp_inc;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> src/lzd_checker.sv
// Port-level checks for the decoder output, bound to the top level.
module lzd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata[7:0] == 8'd0)
        else $error("end status not last or carries a byte");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[42:8] == 35'd0)
        else $error("byte word carries status or crc");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] != m_tuser[1] && m_tdata[10:8] != 3'd7)
        else $error("bad result kind or status");

endmodule

bind lzss_store_decoder_crc32 lzd_checker u_lzd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
